// File: rtl/core/edge_upwind_stencil_core_macros.svh
// assertion macros shared by the edge upwind stencil rtl
// no dependencies; assertions compile out under SYNTHESIS
`ifndef EDGE_UPWIND_STENCIL_CORE_MACROS_SVH
`define EDGE_UPWIND_STENCIL_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define EUS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("edge upwind stencil assertion failed");
// next-cycle implication
`define EUS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("edge upwind stencil assertion failed");
`else
`define EUS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define EUS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/core/eus_pkg.sv
// shared types, constants and tables of the edge upwind stencil
// no dependencies
package eus_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 4;
  localparam int EXP_BITS        = 21;
  localparam int DIV_BITS        = 17;

  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [16:0] HALF_Q16 = 17'd32768;

  // weight rule codes
  localparam logic [1:0] RULE_UPWIND    = 2'd0;
  localparam logic [1:0] RULE_SAMARSKII = 2'd1;
  localparam logic [1:0] RULE_EXP       = 2'd2;
  localparam logic [1:0] RULE_CENTERED  = 2'd3;

  // configuration register indexes
  localparam logic CFG_IDX_RULE = 1'b0;
  localparam logic CFG_IDX_FORM = 1'b1;

  // exp(-2^(k-16)) in q0.32
  localparam logic [31:0] EXP_NEG_BIT [EXP_BITS] = '{
    32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040, 32'd4293918848,
    32'd4292870656, 32'd4290775039, 32'd4286586875, 32'd4278222806, 32'd4261543605,
    32'd4228380000, 32'd4162825044, 32'd4034748382, 32'd3790295335, 32'd3344923893,
    32'd2605029347, 32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801,
    32'd483
  };

  // classified edge as it sits in the queue
  typedef struct packed {
    logic signed [31:0] flux;
    logic signed [32:0] x;
    logic signed [1:0]  s1;
    logic signed [1:0]  s2;
    logic               flux_zero;
  } edge_t;

endpackage

// File: rtl/core/eus_front.sv
// front end: unpacks an input item, decodes signs and forms the criterion x
// depends on eus_pkg
module eus_front (
  input  logic [71:0]    s_tdata_i,
  output eus_pkg::edge_t edge_o
);

  logic signed [31:0] crit;
  logic signed [32:0] crit_ext;
  logic signed [1:0]  s1;
  logic signed [1:0]  s2;

  // sign decode: any negative pattern counts as minus one
  function automatic logic signed [1:0] dec_sign(input logic [1:0] raw);
    logic signed [1:0] r;
    case (raw)
      2'b01:   r = 2'sd1;
      2'b00:   r = 2'sd0;
      default: r = -2'sd1;
    endcase
    return r;
  endfunction

  assign crit     = s_tdata_i[63:32];
  assign crit_ext = 33'(crit);
  assign s1       = dec_sign(s_tdata_i[65:64]);
  assign s2       = dec_sign(s_tdata_i[67:66]);

  // x = -s1 * criterion
  always_comb begin
    edge_o.flux      = s_tdata_i[31:0];
    edge_o.s1        = s1;
    edge_o.s2        = s2;
    edge_o.flux_zero = (s_tdata_i[31:0] == 32'd0);
    if (s1 == 2'sd1) begin
      edge_o.x = -crit_ext;
    end else if (s1 == 2'sd0) begin
      edge_o.x = '0;
    end else begin
      edge_o.x = crit_ext;
    end
  end

endmodule

// File: rtl/core/eus_fifo.sv
// short queue of classified edges between front and back
// depends on eus_pkg; depth must be a power of two
`include "edge_upwind_stencil_core_macros.svh"
module eus_fifo #(
  parameter int DEPTH = eus_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  eus_pkg::edge_t data_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output eus_pkg::edge_t data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  eus_pkg::edge_t mem_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign ready_o = (cnt_q != CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `EUS_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(DEPTH))
  `EUS_ASSERT_NXT(a_cnt_inc, clk_i, rst_ni, do_push && !do_pop, cnt_q == $past(cnt_q) + CW'(1))
  `EUS_ASSERT_NXT(a_cnt_dec, clk_i, rst_ni, do_pop && !do_push, cnt_q == $past(cnt_q) - CW'(1))

endmodule

// File: rtl/core/eus_back.sv
// back end: weight pipeline (exp product chain and restoring divider),
// flux product, stencil forms, saturation and output register; uses eus_pkg
`include "edge_upwind_stencil_core_macros.svh"
module eus_back #(
  parameter int VALUE_WIDTH = eus_pkg::VALUE_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     weight_rule_i,
  input  logic           conservative_i,
  input  logic           q_valid_i,
  input  eus_pkg::edge_t q_data_i,
  output logic           q_pop_o,
  output logic           m_tvalid_o,
  input  logic           m_tready_i,
  output logic           m_active_o,
  output logic [16:0]    m_weight_o,
  output logic [31:0]    m_diag_first_o,
  output logic [31:0]    m_diag_second_o,
  output logic [31:0]    m_off_fs_o,
  output logic [31:0]    m_off_sf_o
);

  localparam int NST = eus_pkg::EXP_BITS;
  localparam int SCW = (VALUE_WIDTH > 36) ? VALUE_WIDTH + 1 : 37;
  localparam logic signed [SCW-1:0] SAT_HI =
    {{(SCW - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
  localparam logic signed [SCW-1:0] SAT_LO = ~SAT_HI;

  typedef struct packed {
    logic           valid;
    eus_pkg::edge_t e;
    logic [32:0]    acc;
    logic           kill;
    logic [20:0]    t;
    logic [50:0]    rem;
    logic [33:0]    dvs;
    logic [16:0]    quo;
  } stage_t;

  stage_t st_q [NST+1];
  stage_t st_d [NST+1];
  logic   en;

  // whole back end moves while the output register is free or being taken
  assign en      = !m_tvalid_o || m_tready_i;
  assign q_pop_o = en;

  // entry: |x| for exp, dividend and divisor for the samarskii quotient
  logic [32:0] ax;
  logic [50:0] num, den;
  always_comb begin
    ax = q_data_i.x[32] ? 33'(-q_data_i.x) : 33'(q_data_i.x);
    if (q_data_i.x[32]) begin
      num = 51'd1 << 32;
      den = 51'd131072 + 51'(ax);
    end else begin
      num = 51'(65536 + 33'(q_data_i.x)) << 16;
      den = 51'd131072 + 51'(q_data_i.x);
    end
    st_d[0].valid = q_valid_i;
    st_d[0].e     = q_data_i;
    st_d[0].acc   = 33'd1 << 32;
    st_d[0].kill  = |ax[32:21];
    st_d[0].t     = ax[20:0];
    st_d[0].rem   = (num << 1) + den;
    st_d[0].dvs   = 34'(den << 1);
    st_d[0].quo   = '0;
  end

  // one exp factor per stage; one quotient bit in each of the first DIV_BITS stages
  for (genvar k = 0; k < NST; k++) begin : g_stage
    localparam int B = (k < eus_pkg::DIV_BITS) ? eus_pkg::DIV_BITS - 1 - k : 0;
    logic [64:0] eprod;
    logic [50:0] dsh;
    assign eprod = 65'(st_q[k].acc) * 65'(eus_pkg::EXP_NEG_BIT[k]) + (65'd1 << 31);
    assign dsh   = 51'(st_q[k].dvs) << B;
    always_comb begin
      st_d[k+1] = st_q[k];
      if (st_q[k].t[k]) begin
        st_d[k+1].acc = eprod[64:32];
      end
      if ((k < eus_pkg::DIV_BITS) && (st_q[k].rem >= dsh)) begin
        st_d[k+1].rem    = st_q[k].rem - dsh;
        st_d[k+1].quo[B] = 1'b1;
      end
    end
  end

  for (genvar k = 0; k <= NST; k++) begin : g_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[k] <= '0;
      end else if (en) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // weight select
  stage_t      wl;
  logic [16:0] h, w;
  logic [33:0] hsum;
  assign wl   = st_q[NST];
  assign hsum = 34'(wl.acc) + 34'd65536;
  always_comb begin
    h = wl.kill ? 17'd0 : hsum[33:17];
    case (weight_rule_i)
      eus_pkg::RULE_UPWIND: begin
        if (wl.e.x == '0) begin
          w = eus_pkg::HALF_Q16;
        end else if (wl.e.x[32]) begin
          w = '0;
        end else begin
          w = eus_pkg::ONE_Q16;
        end
      end
      eus_pkg::RULE_SAMARSKII: w = wl.quo;
      eus_pkg::RULE_EXP:       w = wl.e.x[32] ? h : eus_pkg::ONE_Q16 - h;
      default:                 w = eus_pkg::HALF_Q16;
    endcase
    if (wl.e.flux_zero) begin
      w = '0;
    end
  end

  // flux times weight
  logic               mv_q;
  eus_pkg::edge_t     me_q;
  logic [16:0]        mw_q;
  logic signed [49:0] mp_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (en) begin
      mv_q <= wl.valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      me_q <= wl.e;
      mw_q <= w;
      mp_q <= 50'(wl.e.flux) * $signed({1'b0, w});
    end
  end

  // rounding, stencil form and saturation
  function automatic logic signed [35:0] by_sign(input logic signed [1:0] s,
                                                 input logic signed [34:0] v);
    logic signed [35:0] r;
    if (s == 2'sd1) begin
      r = 36'(v);
    end else if (s == 2'sd0) begin
      r = '0;
    end else begin
      r = -36'(v);
    end
    return r;
  endfunction

  function automatic logic [31:0] sat(input logic signed [35:0] v);
    logic signed [SCW-1:0] ve;
    ve = SCW'(v);
    if (ve > SAT_HI) begin
      ve = SAT_HI;
    end else if (ve < SAT_LO) begin
      ve = SAT_LO;
    end
    return ve[31:0];
  endfunction

  logic signed [49:0] prnd;
  logic signed [34:0] cw, cmw;
  logic signed [35:0] d1, d2, o12, o21;
  always_comb begin
    prnd = mp_q + 50'sd32768;
    cw   = 35'($signed(prnd[49:16]));
    cmw  = 35'(me_q.flux) - cw;
    if (conservative_i) begin
      d1  = -by_sign(me_q.s1, cw);
      d2  = -by_sign(me_q.s2, cmw);
      o12 = -by_sign(me_q.s1, cmw);
      o21 = -by_sign(me_q.s2, cw);
    end else begin
      d1  = by_sign(me_q.s1, cmw);
      d2  = by_sign(me_q.s2, cw);
      o12 = by_sign(me_q.s2, cmw);
      o21 = by_sign(me_q.s1, cw);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_o <= 1'b0;
    end else if (en) begin
      m_tvalid_o <= mv_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_active_o      <= !me_q.flux_zero;
      m_weight_o      <= mw_q;
      m_diag_first_o  <= me_q.flux_zero ? 32'd0 : sat(d1);
      m_diag_second_o <= me_q.flux_zero ? 32'd0 : sat(d2);
      m_off_fs_o      <= me_q.flux_zero ? 32'd0 : sat(o12);
      m_off_sf_o      <= me_q.flux_zero ? 32'd0 : sat(o21);
    end
  end

  `EUS_ASSERT_IMP(a_weight_range, clk_i, rst_ni, m_tvalid_o, m_weight_o <= eus_pkg::ONE_Q16)
  `EUS_ASSERT_IMP(a_idle_zero, clk_i, rst_ni, m_tvalid_o && !m_active_o, (m_weight_o == '0) && (m_diag_first_o == '0) && (m_off_sf_o == '0))
  `EUS_ASSERT_IMP(a_upwind_codes, clk_i, rst_ni, m_tvalid_o && m_active_o && (weight_rule_i == eus_pkg::RULE_UPWIND), (m_weight_o == '0) || (m_weight_o == eus_pkg::HALF_Q16) || (m_weight_o == eus_pkg::ONE_Q16))

endmodule

// File: rtl/core/edge_upwind_stencil_core.sv
// path from input acceptance to result valid: queue write,
// 22-register exp and divider pipeline, flux product, output register
// throughput: one edge per cycle while the output is not stalled, set by the fully pipelined weight chain
// reset: async active low; clears the queue, stage valids and the registers
// (weight_rule upwind, non-conservative form)
// depends on eus_pkg, eus_front, eus_fifo, eus_back
module edge_upwind_stencil_core #(
  parameter int VALUE_WIDTH = eus_pkg::VALUE_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [1:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // edge_flux[31:0], upwind_criterion[63:32], sign_first[65:64],
  // sign_second[67:66], zero fill above
  input  logic [71:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // weight_first[16:0], diag_first_add[48:17], diag_second_add[80:49],
  // off_first_second[112:81], off_second_first[144:113], zero fill above
  output logic [151:0] m_axis_tdata,
  // active[0]
  output logic         m_axis_tuser
);

  logic [1:0]     weight_rule_q;
  logic           conservative_q;
  eus_pkg::edge_t fe, qe;
  logic           q_valid, q_pop;
  logic [16:0]    wgt;
  logic [31:0]    d1, d2, o12, o21;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_rule_q  <= eus_pkg::RULE_UPWIND;
      conservative_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        eus_pkg::CFG_IDX_RULE: weight_rule_q  <= cfg_wdata_i;
        eus_pkg::CFG_IDX_FORM: conservative_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  eus_front u_front (
    .s_tdata_i (s_axis_tdata),
    .edge_o    (fe)
  );

  eus_fifo #(
    .DEPTH (eus_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .data_i  (fe),
    .ready_o (s_axis_tready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (qe)
  );

  eus_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .weight_rule_i   (weight_rule_q),
    .conservative_i  (conservative_q),
    .q_valid_i       (q_valid),
    .q_data_i        (qe),
    .q_pop_o         (q_pop),
    .m_tvalid_o      (m_axis_tvalid),
    .m_tready_i      (m_axis_tready),
    .m_active_o      (m_axis_tuser),
    .m_weight_o      (wgt),
    .m_diag_first_o  (d1),
    .m_diag_second_o (d2),
    .m_off_fs_o      (o12),
    .m_off_sf_o      (o21)
  );

  assign m_axis_tdata = {7'd0, o21, o12, d2, d1, wgt};

endmodule
